// ===== hdl/bwp_pkg.sv =====
// ---------------------------------------------------------------------------
// bwp_pkg: shared types and constants of the ball world physics step
// Ball record layout, datapath commands, controller states and the
// saturation helper used by every Q16.16 update.
// ---------------------------------------------------------------------------
package bwp_pkg;

  localparam int DEF_MAX_BALLS = 16;

  // configuration register reset values
  localparam logic signed [31:0] GRAVITY_RST = 32'sd642253;
  localparam logic [30:0]        MAPW_RST    = 31'd41943040;
  localparam logic [30:0]        MAPH_RST    = 31'd31457280;

  // configuration register indexes
  localparam logic [1:0] CFG_GRAVITY    = 2'd0;
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;

  // item kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // one stored ball
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        rad;
    logic [16:0]        bnc;
  } ball_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ADD,
    OP_TAKE_DT,
    OP_LOAD_A,
    OP_LOAD_B,
    OP_MUL_G,
    OP_ADD_VY,
    OP_MUL_VX,
    OP_ADD_PX,
    OP_MUL_VY,
    OP_ADD_PY,
    OP_WALL_LO,
    OP_WALL_HI,
    OP_MUL_REFL,
    OP_SET_V,
    OP_DIFF,
    OP_MUL_AX,
    OP_MUL_AY,
    OP_MUL_RS,
    OP_SQRT_GO,
    OP_SQRT_TAKE,
    OP_MUL_MX,
    OP_MUL_MY,
    OP_DIV_GO,
    OP_TAKE_MX,
    OP_TAKE_MY,
    OP_PUSH,
    OP_WR_A,
    OP_WR_B,
    OP_OUT_NT,
    OP_OUT_BALL
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t     op;
    logic       axis;
    logic [3:0] idx;
    logic [4:0] count;
    logic       last;
    logic       refused;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic far;
    logic refl;
    logic iter_done;
  } stat_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_NT_RES,
    S_RD_A,
    S_LD_A,
    S_MUL_G,
    S_ADD_VY,
    S_MUL_VX,
    S_ADD_PX,
    S_MUL_VY,
    S_ADD_PY,
    S_WLO,
    S_WLO_M,
    S_WLO_S,
    S_WHI,
    S_WHI_M,
    S_WHI_S,
    S_WEND,
    S_NEXT_J,
    S_RD_B,
    S_LD_B,
    S_DIFF,
    S_CHK,
    S_MAY,
    S_MRS,
    S_FAR,
    S_SQW,
    S_MMX,
    S_DXG,
    S_DXW,
    S_MMY,
    S_DYG,
    S_DYW,
    S_PUSH,
    S_WR_B,
    S_WR_A,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] res;
    if (v[51:31] == {21{v[51]}}) begin
      res = v[31:0];
    end else if (v[51]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7fff_ffff;
    end
    return res;
  endfunction

endpackage

// ===== hdl/bwp_if.sv =====
// ---------------------------------------------------------------------------
// bwp channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ---------------------------------------------------------------------------
interface bwp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [30:0] radius;
  logic signed [31:0] start_pos_x;
  logic signed [31:0] start_pos_y;
  logic signed [31:0] start_vel_x;
  logic signed [31:0] start_vel_y;
  logic [16:0] bounce;
  logic [15:0] step_time;
  modport source (output valid, kind, radius, start_pos_x, start_pos_y,
                  start_vel_x, start_vel_y, bounce, step_time, input ready);
  modport sink (input valid, kind, radius, start_pos_x, start_pos_y,
                start_vel_x, start_vel_y, bounce, step_time, output ready);
endinterface

interface bwp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  ball_index;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic [4:0]  ball_count;
  logic        refused;
  logic        last_of_run;
  modport source (output valid, ball_index, new_pos_x, new_pos_y, new_vel_x,
                  new_vel_y, ball_count, refused, last_of_run, input ready);
  modport sink (input valid, ball_index, new_pos_x, new_pos_y, new_vel_x,
                new_vel_y, ball_count, refused, last_of_run, output ready);
endinterface

interface bwp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/ball_world_physics_step_top.sv =====
// ---------------------------------------------------------------------------
// ball_world_physics_step_top: fixed point ball world stepper
// Store of circles advanced by semi-implicit Euler with walls and pair push.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries one item per transaction: add a ball, remove the last,
//   clear, or tick with step_time. out_chan returns the results: one per
//   live ball on a tick (ball_index 0 up, last_of_run on the final one),
//   otherwise a single result with ball_count and refused.
//   cfg_chan writes gravity, map_width and map_height; it is always ready
//   and the user must write it only while no item is in flight (not enforced).
// Sequencing:
//   a non-tick result goes through S_NT_RES into the result register once
//   its item is accepted. A tick updates each ball (longer when a wall
//   reflects), then checks the pair with each later ball, at greater length
//   when it overlaps (one 32-step square root and two 32-step divides in the
//   shared iteration unit), then reads the results out one by one.
//   One item is in work at a time; in_chan is ready only when idle.
// Reset:
//   rst_n (synchronous) empties the store and restores register defaults.
// Stall:
//   a result is held in the output register until out_chan takes it; the
//   block waits meanwhile.
// ---------------------------------------------------------------------------
module ball_world_physics_step_top #(
  parameter int MAX_BALLS = bwp_pkg::DEF_MAX_BALLS
) (
  input  logic   clk,
  input  logic   rst_n,
  bwp_in_if.sink   in_chan,
  bwp_out_if.source out_chan,
  bwp_cfg_if.sink  cfg_chan
);
  import bwp_pkg::*;

  localparam int IW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;

  cmd_t          cmd;
  stat_t         stat;
  logic [IW-1:0] addr;
  ball_t         new_ball;

  // incoming ball record
  always_comb begin
    new_ball.px  = in_chan.start_pos_x;
    new_ball.py  = in_chan.start_pos_y;
    new_ball.vx  = in_chan.start_vel_x;
    new_ball.vy  = in_chan.start_vel_y;
    new_ball.rad = in_chan.radius;
    new_ball.bnc = in_chan.bounce;
  end

  assign cfg_chan.ready = 1'b1;

  bwp_ctrl #(
    .MAX_BALLS (MAX_BALLS),
    .IW        (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_kind   (in_chan.kind),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .addr      (addr),
    .stat      (stat)
  );

  bwp_dpath #(
    .MAX_BALLS (MAX_BALLS),
    .IW        (IW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr      (addr),
    .stat      (stat),
    .new_ball  (new_ball),
    .in_dt     (in_chan.step_time),
    .cfg_we    (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .o_idx     (out_chan.ball_index),
    .o_px      (out_chan.new_pos_x),
    .o_py      (out_chan.new_pos_y),
    .o_vx      (out_chan.new_vel_x),
    .o_vy      (out_chan.new_vel_y),
    .o_count   (out_chan.ball_count),
    .o_refused (out_chan.refused),
    .o_last    (out_chan.last_of_run)
  );

endmodule

// ===== hdl/bwp_ram.sv =====
// ---------------------------------------------------------------------------
// bwp_ram: generic single-port-write ram
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bwp_iter.sv =====
// ---------------------------------------------------------------------------
// bwp_iter: shared iterative square root and divider
// Integer square root of a 64-bit value, or a 64 by 33-bit quotient known
// to fit in 32 bits; one result bit per cycle in either mode.
// ---------------------------------------------------------------------------
module bwp_iter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_div,
  input  logic [63:0] opnd,
  input  logic [32:0] den,
  output logic        done,
  output logic [31:0] res
);

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] rt_r, rt_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [32:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r, div_r;

  logic [63:0] trial;
  logic [34:0] shifted;
  logic        ge;

  // one step of the active operation
  always_comb begin
    trial   = rt_r + bit_r;
    shifted = {acc_r[33:0], rt_r[31]};
    acc_nxt = acc_r;
    rt_nxt  = rt_r;
    bit_nxt = bit_r >> 2;
    ge      = 1'b0;
    if (div_r) begin
      ge      = shifted >= {2'b00, den_r};
      acc_nxt = {30'd0, ge ? 34'(shifted - {2'b00, den_r}) : shifted[33:0]};
      rt_nxt  = {32'd0, rt_r[30:0], ge};
    end else begin
      ge = acc_r >= trial;
      if (ge) begin
        acc_nxt = acc_r - trial;
        rt_nxt  = (rt_r >> 1) + bit_r;
      end else begin
        rt_nxt  = rt_r >> 1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= is_div;
      den_r <= den;
      bit_r <= 64'd1 << 62;
      if (is_div) begin
        acc_r <= {32'd0, opnd[63:32]};
        rt_r  <= {32'd0, opnd[31:0]};
      end else begin
        acc_r <= opnd;
        rt_r  <= '0;
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rt_r  <= rt_nxt;
      bit_r <= bit_nxt;
    end
  end

  assign done = done_r;
  assign res  = rt_r[31:0];

endmodule

// ===== hdl/bwp_dpath.sv =====
// ---------------------------------------------------------------------------
// bwp_dpath: ball world datapath
// Ball store, working ball registers, shared multiplier, square root and
// divider unit, configuration registers and the result register.
// ---------------------------------------------------------------------------
module bwp_dpath #(
  parameter int MAX_BALLS = bwp_pkg::DEF_MAX_BALLS,
  parameter int IW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bwp_pkg::cmd_t       cmd,
  input  logic [IW-1:0]       addr,
  output bwp_pkg::stat_t      stat,
  input  bwp_pkg::ball_t      new_ball,
  input  logic [15:0]         in_dt,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic [3:0]          o_idx,
  output logic signed [31:0]  o_px,
  output logic signed [31:0]  o_py,
  output logic signed [31:0]  o_vx,
  output logic signed [31:0]  o_vy,
  output logic [4:0]          o_count,
  output logic                o_refused,
  output logic                o_last
);
  import bwp_pkg::*;

  // configuration
  logic signed [31:0] grav_r;
  logic [30:0]        mapw_r, maph_r;

  // working registers
  ball_t a_r, a_nxt, b_r, b_nxt;
  logic [15:0]         dt_r;
  logic signed [65:0]  prod_r;
  logic                refl_r, refl_nxt;
  logic signed [32:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic [32:0]         adx_r, ady_r, adx_nxt, ady_nxt;
  logic [31:0]         rs_r, rs_nxt;
  logic [64:0]         s_r, s_nxt;
  logic [31:0]         d_r, d_nxt, ov_r, ov_nxt, mx_r, mx_nxt, my_r, my_nxt;

  // store and iteration unit
  ball_t               rdata, wdata;
  logic                ram_we;
  logic                iter_start, iter_div, iter_done;
  logic [31:0]         iter_res;

  // multiplier operands
  logic signed [32:0]  mul_a, mul_b;
  logic                mul_en;

  // wall helpers
  logic signed [31:0]  p_sel, v_sel;
  logic [30:0]         lim;
  logic signed [32:0]  hi;
  logic signed [49:0]  prod_sh;
  logic signed [32:0]  mxs, mys;

  bwp_ram #(
    .WIDTH ($bits(ball_t)),
    .DEPTH (MAX_BALLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  bwp_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (iter_start),
    .is_div (iter_div),
    .opnd   (iter_div ? prod_r[63:0] : s_r[63:0]),
    .den    ({d_r, 1'b0}),
    .done   (iter_done),
    .res    (iter_res)
  );

  // store writes
  always_comb begin
    ram_we = (cmd.op == OP_ADD) || (cmd.op == OP_WR_A) || (cmd.op == OP_WR_B);
    case (cmd.op)
      OP_WR_A: wdata = a_r;
      OP_WR_B: wdata = b_r;
      default: wdata = new_ball;
    endcase
  end

  assign iter_start = (cmd.op == OP_SQRT_GO) || (cmd.op == OP_DIV_GO);
  assign iter_div   = (cmd.op == OP_DIV_GO);

  // multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_MUL_G: begin
        mul_a = {grav_r[31], grav_r};
        mul_b = {17'd0, dt_r};
      end
      OP_MUL_VX: begin
        mul_a = {a_r.vx[31], a_r.vx};
        mul_b = {17'd0, dt_r};
      end
      OP_MUL_VY: begin
        mul_a = {a_r.vy[31], a_r.vy};
        mul_b = {17'd0, dt_r};
      end
      OP_MUL_REFL: begin
        mul_a = -{v_sel[31], v_sel};
        mul_b = {16'd0, a_r.bnc};
      end
      OP_MUL_AX: begin
        mul_a = adx_r;
        mul_b = adx_r;
      end
      OP_MUL_AY: begin
        mul_a = ady_r;
        mul_b = ady_r;
      end
      OP_MUL_RS: begin
        mul_a = {1'b0, rs_r};
        mul_b = {1'b0, rs_r};
      end
      OP_MUL_MX: begin
        mul_a = adx_r;
        mul_b = {1'b0, ov_r};
      end
      OP_MUL_MY: begin
        mul_a = ady_r;
        mul_b = {1'b0, ov_r};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // axis selection for the wall steps and signed push amounts
  always_comb begin
    p_sel   = cmd.axis ? a_r.py : a_r.px;
    v_sel   = cmd.axis ? a_r.vy : a_r.vx;
    lim     = cmd.axis ? maph_r : mapw_r;
    hi      = $signed({2'b00, lim}) - $signed({2'b00, a_r.rad});
    prod_sh = prod_r[65:16];
    mxs     = dx_r[32] ? -$signed({1'b0, mx_r}) : $signed({1'b0, mx_r});
    mys     = dy_r[32] ? -$signed({1'b0, my_r}) : $signed({1'b0, my_r});
  end

  // next values of the working registers
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    refl_nxt = refl_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    adx_nxt  = adx_r;
    ady_nxt  = ady_r;
    rs_nxt   = rs_r;
    s_nxt    = s_r;
    d_nxt    = d_r;
    ov_nxt   = ov_r;
    mx_nxt   = mx_r;
    my_nxt   = my_r;
    case (cmd.op)
      OP_LOAD_A: a_nxt = rdata;
      OP_LOAD_B: b_nxt = rdata;
      OP_ADD_VY: a_nxt.vy = sat32({{20{a_r.vy[31]}}, a_r.vy} + {{2{prod_sh[49]}}, prod_sh});
      OP_ADD_PX: a_nxt.px = sat32({{20{a_r.px[31]}}, a_r.px} + {{2{prod_sh[49]}}, prod_sh});
      OP_ADD_PY: a_nxt.py = sat32({{20{a_r.py[31]}}, a_r.py} + {{2{prod_sh[49]}}, prod_sh});
      OP_WALL_LO: begin
        refl_nxt = 1'b0;
        if ($signed({p_sel[31], p_sel}) <= $signed({2'b00, a_r.rad})) begin
          refl_nxt = v_sel[31];
          if (cmd.axis) begin
            a_nxt.py = {1'b0, a_r.rad};
          end else begin
            a_nxt.px = {1'b0, a_r.rad};
          end
        end
      end
      OP_WALL_HI: begin
        refl_nxt = 1'b0;
        if ($signed({p_sel[31], p_sel}) >= hi) begin
          refl_nxt = !v_sel[31] && (v_sel != 32'sd0);
          if (cmd.axis) begin
            a_nxt.py = hi[31:0];
          end else begin
            a_nxt.px = hi[31:0];
          end
        end
      end
      OP_SET_V: begin
        if (cmd.axis) begin
          a_nxt.vy = sat32({{2{prod_sh[49]}}, prod_sh});
        end else begin
          a_nxt.vx = sat32({{2{prod_sh[49]}}, prod_sh});
        end
      end
      OP_DIFF: begin
        dx_nxt  = $signed({b_r.px[31], b_r.px}) - $signed({a_r.px[31], a_r.px});
        dy_nxt  = $signed({b_r.py[31], b_r.py}) - $signed({a_r.py[31], a_r.py});
        adx_nxt = dx_nxt[32] ? 33'(-dx_nxt) : dx_nxt;
        ady_nxt = dy_nxt[32] ? 33'(-dy_nxt) : dy_nxt;
        rs_nxt  = {1'b0, a_r.rad} + {1'b0, b_r.rad};
      end
      OP_MUL_AY: s_nxt = {1'b0, prod_r[63:0]};
      OP_MUL_RS: s_nxt = s_r + {1'b0, prod_r[63:0]};
      OP_SQRT_TAKE: begin
        d_nxt  = iter_res;
        ov_nxt = rs_r - iter_res;
      end
      OP_TAKE_MX: mx_nxt = iter_res;
      OP_TAKE_MY: my_nxt = iter_res;
      OP_PUSH: begin
        a_nxt.px = sat32({{20{a_r.px[31]}}, a_r.px} - {{19{mxs[32]}}, mxs});
        a_nxt.py = sat32({{20{a_r.py[31]}}, a_r.py} - {{19{mys[32]}}, mys});
        b_nxt.px = sat32({{20{b_r.px[31]}}, b_r.px} + {{19{mxs[32]}}, mxs});
        b_nxt.py = sat32({{20{b_r.py[31]}}, b_r.py} + {{19{mys[32]}}, mys});
      end
      default: ;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    refl_r <= refl_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    adx_r  <= adx_nxt;
    ady_r  <= ady_nxt;
    rs_r   <= rs_nxt;
    s_r    <= s_nxt;
    d_r    <= d_nxt;
    ov_r   <= ov_nxt;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.op == OP_TAKE_DT) begin
      dt_r <= in_dt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAVITY_RST;
      mapw_r <= MAPW_RST;
      maph_r <= MAPH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAVITY:    grav_r <= cfg_data;
        CFG_MAP_WIDTH:  mapw_r <= cfg_data[30:0];
        CFG_MAP_HEIGHT: maph_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_OUT_NT: begin
        o_idx     <= '0;
        o_px      <= '0;
        o_py      <= '0;
        o_vx      <= '0;
        o_vy      <= '0;
        o_count   <= cmd.count;
        o_refused <= cmd.refused;
        o_last    <= 1'b1;
      end
      OP_OUT_BALL: begin
        o_idx     <= cmd.idx;
        o_px      <= rdata.px;
        o_py      <= rdata.py;
        o_vx      <= rdata.vx;
        o_vy      <= rdata.vy;
        o_count   <= cmd.count;
        o_refused <= 1'b0;
        o_last    <= cmd.last;
      end
      default: ;
    endcase
  end

  // status back to the controller
  always_comb begin
    stat.skip      = ((dx_r == 33'sd0) && (dy_r == 33'sd0)) ||
                     (adx_r >= {1'b0, rs_r}) || (ady_r >= {1'b0, rs_r});
    stat.far       = s_r >= {1'b0, prod_r[63:0]};
    stat.refl      = refl_r;
    stat.iter_done = iter_done;
  end

endmodule

// ===== hdl/bwp_ctrl.sv =====
// ---------------------------------------------------------------------------
// bwp_ctrl: ball world controller
// Sequences items, the per-ball update, the pair walk and result delivery;
// holds the live ball count.
// ---------------------------------------------------------------------------
module bwp_ctrl #(
  parameter int MAX_BALLS = bwp_pkg::DEF_MAX_BALLS,
  parameter int IW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_kind,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output bwp_pkg::cmd_t  cmd,
  output logic [IW-1:0]  addr,
  input  bwp_pkg::stat_t stat
);
  import bwp_pkg::*;

  localparam int CW = $clog2(MAX_BALLS + 1);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic            axis_r, axis_nxt;
  logic            refused_r, refused_nxt;
  logic            last_r, last_nxt;
  logic            in_fire, full;

  assign in_fire = in_valid && (state_r == S_IDLE);
  assign full    = (cnt_r == CW'(MAX_BALLS));

  // next state and counters
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    axis_nxt    = axis_r;
    refused_nxt = refused_r;
    last_nxt    = last_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          refused_nxt = 1'b0;
          state_nxt   = S_NT_RES;
          case (in_kind)
            KIND_ADD: begin
              if (full) begin
                refused_nxt = 1'b1;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            KIND_CLEAR: cnt_nxt = '0;
            KIND_TICK: begin
              i_nxt = '0;
              if (cnt_r != '0) begin
                state_nxt = S_RD_A;
              end
            end
            default: ;
          endcase
        end
      end
      S_NT_RES: begin
        last_nxt  = 1'b1;
        state_nxt = S_OUT_WAIT;
      end
      S_RD_A:   state_nxt = S_LD_A;
      S_LD_A: begin
        axis_nxt  = 1'b0;
        state_nxt = S_MUL_G;
      end
      S_MUL_G:  state_nxt = S_ADD_VY;
      S_ADD_VY: state_nxt = S_MUL_VX;
      S_MUL_VX: state_nxt = S_ADD_PX;
      S_ADD_PX: state_nxt = S_MUL_VY;
      S_MUL_VY: state_nxt = S_ADD_PY;
      S_ADD_PY: state_nxt = S_WLO;
      S_WLO:    state_nxt = S_WLO_M;
      S_WLO_M:  state_nxt = stat.refl ? S_WLO_S : S_WHI;
      S_WLO_S:  state_nxt = S_WHI;
      S_WHI:    state_nxt = S_WHI_M;
      S_WHI_M:  state_nxt = stat.refl ? S_WHI_S : S_WEND;
      S_WHI_S:  state_nxt = S_WEND;
      S_WEND: begin
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_WLO;
        end else begin
          j_nxt     = i_r;
          state_nxt = S_NEXT_J;
        end
      end
      S_NEXT_J: begin
        if ((j_r + 1'b1) < cnt_r) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RD_B;
        end else begin
          state_nxt = S_WR_A;
        end
      end
      S_RD_B:   state_nxt = S_LD_B;
      S_LD_B:   state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_CHK;
      S_CHK:    state_nxt = stat.skip ? S_NEXT_J : S_MAY;
      S_MAY:    state_nxt = S_MRS;
      S_MRS:    state_nxt = S_FAR;
      S_FAR:    state_nxt = stat.far ? S_NEXT_J : S_SQW;
      S_SQW:    state_nxt = stat.iter_done ? S_MMX : S_SQW;
      S_MMX:    state_nxt = S_DXG;
      S_DXG:    state_nxt = S_DXW;
      S_DXW:    state_nxt = stat.iter_done ? S_MMY : S_DXW;
      S_MMY:    state_nxt = S_DYG;
      S_DYG:    state_nxt = S_DYW;
      S_DYW:    state_nxt = stat.iter_done ? S_PUSH : S_DYW;
      S_PUSH:   state_nxt = S_WR_B;
      S_WR_B:   state_nxt = S_NEXT_J;
      S_WR_A: begin
        if ((i_r + 1'b1) < cnt_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RD_A;
        end else begin
          k_nxt     = '0;
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_LD;
      S_OUT_LD: begin
        last_nxt  = ((k_r + 1'b1) == cnt_r);
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_ready    = (state_r == S_IDLE);
    out_valid   = (state_r == S_OUT_WAIT);
    cmd.op      = OP_NONE;
    cmd.axis    = axis_r;
    cmd.idx     = 4'(k_r);
    cmd.count   = 5'(cnt_r);
    cmd.last    = ((k_r + 1'b1) == cnt_r);
    cmd.refused = refused_r;
    addr        = '0;
    case (state_r)
      S_IDLE: begin
        addr = cnt_r[IW-1:0];
        if (in_fire && (in_kind == KIND_ADD) && !full) begin
          cmd.op = OP_ADD;
        end else if (in_fire && (in_kind == KIND_TICK)) begin
          cmd.op = OP_TAKE_DT;
        end
      end
      S_NT_RES: cmd.op = OP_OUT_NT;
      S_RD_A:   addr = i_r[IW-1:0];
      S_LD_A:   cmd.op = OP_LOAD_A;
      S_MUL_G:  cmd.op = OP_MUL_G;
      S_ADD_VY: cmd.op = OP_ADD_VY;
      S_MUL_VX: cmd.op = OP_MUL_VX;
      S_ADD_PX: cmd.op = OP_ADD_PX;
      S_MUL_VY: cmd.op = OP_MUL_VY;
      S_ADD_PY: cmd.op = OP_ADD_PY;
      S_WLO:    cmd.op = OP_WALL_LO;
      S_WLO_M:  cmd.op = stat.refl ? OP_MUL_REFL : OP_NONE;
      S_WLO_S:  cmd.op = OP_SET_V;
      S_WHI:    cmd.op = OP_WALL_HI;
      S_WHI_M:  cmd.op = stat.refl ? OP_MUL_REFL : OP_NONE;
      S_WHI_S:  cmd.op = OP_SET_V;
      S_RD_B:   addr = j_r[IW-1:0];
      S_LD_B:   cmd.op = OP_LOAD_B;
      S_DIFF:   cmd.op = OP_DIFF;
      S_CHK:    cmd.op = stat.skip ? OP_NONE : OP_MUL_AX;
      S_MAY:    cmd.op = OP_MUL_AY;
      S_MRS:    cmd.op = OP_MUL_RS;
      S_FAR:    cmd.op = stat.far ? OP_NONE : OP_SQRT_GO;
      S_SQW:    cmd.op = stat.iter_done ? OP_SQRT_TAKE : OP_NONE;
      S_MMX:    cmd.op = OP_MUL_MX;
      S_DXG:    cmd.op = OP_DIV_GO;
      S_DXW:    cmd.op = stat.iter_done ? OP_TAKE_MX : OP_NONE;
      S_MMY:    cmd.op = OP_MUL_MY;
      S_DYG:    cmd.op = OP_DIV_GO;
      S_DYW:    cmd.op = stat.iter_done ? OP_TAKE_MY : OP_NONE;
      S_PUSH:   cmd.op = OP_PUSH;
      S_WR_B: begin
        cmd.op = OP_WR_B;
        addr   = j_r[IW-1:0];
      end
      S_WR_A: begin
        cmd.op = OP_WR_A;
        addr   = i_r[IW-1:0];
      end
      S_OUT_RD: addr = k_r[IW-1:0];
      S_OUT_LD: cmd.op = OP_OUT_BALL;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      axis_r    <= 1'b0;
      refused_r <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
      axis_r    <= axis_nxt;
      refused_r <= refused_nxt;
      last_r    <= last_nxt;
    end
  end

`ifndef SYNTH
  // never offer a result while taking a new item
  ast_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("item accepted while a result is pending");

  // live count stays within the store
  ast_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_BALLS))
    else $error("live count beyond store depth");

  // the address used by each read state stays below the live count
  ast_addr_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_RD_A) || (i_r < cnt_r)) &&
    ((state_r != S_RD_B) || (j_r < cnt_r)) &&
    ((state_r != S_OUT_RD) || (k_r < cnt_r)))
    else $error("store address beyond live count");

  // the iteration unit only finishes while the controller waits for it
  ast_iter_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.iter_done |-> (state_r == S_SQW || state_r == S_DXW || state_r == S_DYW))
    else $error("iteration result not collected");
`endif

endmodule
